@@ rtl/core/pss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll scheduler package
// Shared widths, defaults and codes for the periodic sensor poll scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int ACTION_W      = 1;
   localparam int SLOT_FIELD_W  = 7;
   localparam int ID_W          = 16;
   localparam int PERIOD_W      = 16;
   localparam int NOW_W         = 48;

   localparam int ACTIVE_W      = 8;
   localparam int EMIT_W        = 7;
   localparam int CSR_DATA_W    = 8;
   localparam int CSR_IDX_W     = 1;

   localparam int DEF_SLOTS     = 128;
   localparam int DEF_TIME_BITS = 48;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 8'd0;
   localparam logic [EMIT_W-1:0]   EMIT_RESET   = 7'd64;
   localparam logic [EMIT_W-1:0]   MAX_RESULTS  = 7'd64;
   localparam logic [EMIT_W-1:0]   MIN_RESULTS  = 7'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_COUNT = 1'b0,
      CSR_MAX_EMIT     = 1'b1
   } csr_idx_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

endpackage

@@ rtl/core/pss_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll scheduler channels
// Request and response channels with valid/ready flow control.
// ----------------------------------------------------------------------------
interface pss_req_if;
   logic                              valid;
   logic                              ready;
   logic [pss_pkg::ACTION_W-1:0]      action;
   logic [pss_pkg::SLOT_FIELD_W-1:0]  slot;
   logic [pss_pkg::ID_W-1:0]          dev_id;
   logic [pss_pkg::PERIOD_W-1:0]      poll_period;
   logic [pss_pkg::NOW_W-1:0]         now_time;

   modport source (output valid, action, slot, dev_id, poll_period, now_time,
                   input ready);
   modport sink   (input valid, action, slot, dev_id, poll_period, now_time,
                   output ready);
endinterface

interface pss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pss_pkg::ID_W-1:0]          due_sensor_id;
   logic [pss_pkg::SLOT_FIELD_W-1:0]  due_slot;
   logic                              any_due;
   logic                              last;

   modport source (output valid, due_sensor_id, due_slot, any_due, last,
                   input ready);
   modport sink   (input valid, due_sensor_id, due_slot, any_due, last,
                   output ready);
endinterface

@@ rtl/core/pss_due_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Due time calculator
// Adds a period to the current time, saturating at the top of the time range.
// ----------------------------------------------------------------------------
module pss_due_calc #(
   parameter int TIME_BITS = pss_pkg::DEF_TIME_BITS
) (
   input  logic [TIME_BITS-1:0]         now_val,
   input  logic [pss_pkg::PERIOD_W-1:0] period_val,
   output logic [TIME_BITS-1:0]         due_val
);

   logic [TIME_BITS:0] sum;

   assign sum = {1'b0, now_val} + (TIME_BITS+1)'(period_val);

   // A carry out means the sum passed the largest representable time.
   assign due_val = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

endmodule

@@ rtl/core/periodic_sensor_poll_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic sensor poll scheduler
// Slot table in one synchronous memory; a tick scans it one slot per cycle
// unless responses stall, emitting due sensors and writing back next due times.
// ----------------------------------------------------------------------------
// Load: written to the slot memory on the edge that accepts it (a slot beyond
//   the table is dropped); the next beat can be taken on the following edge.
// Tick: reads the active slots up to the emit limit, one memory read per cycle
//   unless the response side stalls, through a read-modify-write pipeline; the
//   next beat can be taken once the final response beat is offered.
// Reset clears the control state, the valid flags and the CSR registers; the
//   slot memory is not cleared and has no clearing pass.
// ----------------------------------------------------------------------------
module periodic_sensor_poll_scheduler_unit #(
   parameter int SLOTS     = pss_pkg::DEF_SLOTS,
   parameter int TIME_BITS = pss_pkg::DEF_TIME_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   pss_req_if.sink                          req_chan,
   pss_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [pss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = SLOT_W + 1;
   localparam int WIDE_W  = SLOT_W + pss_pkg::SLOT_FIELD_W;
   localparam int ACT_W   = CNT_W + pss_pkg::ACTIVE_W;
   localparam int ENTRY_W = pss_pkg::ID_W + pss_pkg::PERIOD_W + TIME_BITS;

   // Slot memory: {sensor id, period, due time}.
   logic [ENTRY_W-1:0] mem [SLOTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [pss_pkg::ACTIVE_W-1:0] active_ff;
   logic [pss_pkg::EMIT_W-1:0]   emit_ff;

   pss_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]             scan_n_ff, scan_n_in;
   logic [pss_pkg::EMIT_W-1:0]   limit_ff, limit_in;
   logic [TIME_BITS-1:0]         now_ff, now_in;
   logic [CNT_W-1:0]             rd_cnt_ff, rd_cnt_in;
   logic [pss_pkg::EMIT_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic                         ev_vld_ff, ev_vld_in;
   logic [SLOT_W-1:0]            ev_idx_ff, ev_idx_in;
   logic                         hold_vld_ff, hold_vld_in;
   logic [pss_pkg::ID_W-1:0]     hold_id_ff, hold_id_in;
   logic [pss_pkg::SLOT_FIELD_W-1:0] hold_slot_ff, hold_slot_in;
   logic                         out_vld_ff, out_vld_in;
   logic [pss_pkg::ID_W-1:0]     out_id_ff, out_id_in;
   logic [pss_pkg::SLOT_FIELD_W-1:0] out_slot_ff, out_slot_in;
   logic                         out_any_ff, out_any_in;
   logic                         out_last_ff, out_last_in;

   logic                         req_fire;
   logic                         is_idle;
   logic [TIME_BITS-1:0]         req_now;
   logic [WIDE_W-1:0]            slot_wide;
   logic                         slot_ok;
   logic [WIDE_W-1:0]            ev_idx_wide;
   logic [ACT_W-1:0]             act_wide;

   logic [pss_pkg::ID_W-1:0]     rd_id;
   logic [pss_pkg::PERIOD_W-1:0] rd_period;
   logic [TIME_BITS-1:0]         rd_due;

   logic [TIME_BITS-1:0]         calc_now;
   logic [pss_pkg::PERIOD_W-1:0] calc_period;
   logic [TIME_BITS-1:0]         calc_due;

   logic                         hit;
   logic                         out_free;
   logic                         ev_go;
   logic                         more;
   logic                         issue;
   logic [SLOT_W-1:0]            rd_addr;
   logic                         load_wr;
   logic                         wb_wr;
   logic                         wr_en;
   logic [SLOT_W-1:0]            wr_addr;
   logic [ENTRY_W-1:0]           wr_data;

   assign is_idle        = (state_ff == pss_pkg::ST_IDLE);
   assign req_chan.ready = is_idle;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_now        = TIME_BITS'(64'(req_chan.now_time));
   assign slot_wide      = WIDE_W'(req_chan.slot);
   assign slot_ok        = (slot_wide < WIDE_W'(SLOTS));
   assign ev_idx_wide    = WIDE_W'(ev_idx_ff);
   assign act_wide       = ACT_W'(active_ff);

   assign rd_id     = rd_data_ff[ENTRY_W-1 -: pss_pkg::ID_W];
   assign rd_period = rd_data_ff[TIME_BITS +: pss_pkg::PERIOD_W];
   assign rd_due    = rd_data_ff[TIME_BITS-1:0];

   // One adder serves both loads (only in idle) and scan write-backs.
   assign calc_now    = is_idle ? req_now : now_ff;
   assign calc_period = is_idle ? req_chan.poll_period : rd_period;

   pss_due_calc #(
      .TIME_BITS (TIME_BITS)
   ) u_due_calc (
      .now_val    (calc_now),
      .period_val (calc_period),
      .due_val    (calc_due)
   );

   // A due slot found after the emit limit is ignored and left untouched.
   assign hit      = ev_vld_ff && (now_ff >= rd_due) && (emit_cnt_ff < limit_ff);
   assign out_free = !out_vld_ff || rsp_chan.ready;
   assign ev_go    = !hit || !hold_vld_ff || out_free;
   assign more     = (rd_cnt_ff < scan_n_ff) && (emit_cnt_ff < limit_ff);
   assign issue    = (state_ff == pss_pkg::ST_SCAN) && more && (!ev_vld_ff || ev_go);
   assign rd_addr  = rd_cnt_ff[SLOT_W-1:0];

   assign load_wr = req_fire && (req_chan.action == pss_pkg::ACT_LOAD) && slot_ok;
   assign wb_wr   = hit && ev_go;
   assign wr_en   = load_wr || wb_wr;
   assign wr_addr = load_wr ? slot_wide[SLOT_W-1:0] : ev_idx_ff;
   assign wr_data = load_wr ? {req_chan.dev_id, req_chan.poll_period, calc_due}
                            : {rd_id, rd_period, calc_due};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= pss_pkg::ACTIVE_RESET;
         emit_ff   <= pss_pkg::EMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            pss_pkg::CSR_ACTIVE_COUNT: active_ff <= csr_wdata[pss_pkg::ACTIVE_W-1:0];
            pss_pkg::CSR_MAX_EMIT:     emit_ff   <= csr_wdata[pss_pkg::EMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_n_in    = scan_n_ff;
      limit_in     = limit_ff;
      now_in       = now_ff;
      rd_cnt_in    = rd_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      ev_vld_in    = issue || (ev_vld_ff && !ev_go);
      ev_idx_in    = issue ? rd_addr : ev_idx_ff;
      hold_vld_in  = hold_vld_ff;
      hold_id_in   = hold_id_ff;
      hold_slot_in = hold_slot_ff;
      out_vld_in   = out_vld_ff && !rsp_chan.ready;
      out_id_in    = out_id_ff;
      out_slot_in  = out_slot_ff;
      out_any_in   = out_any_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (req_fire && (req_chan.action == pss_pkg::ACT_TICK)) begin
               if (act_wide > ACT_W'(SLOTS)) begin
                  scan_n_in = CNT_W'(SLOTS);
               end else begin
                  scan_n_in = act_wide[CNT_W-1:0];
               end
               if (emit_ff == '0) begin
                  limit_in = pss_pkg::MIN_RESULTS;
               end else if (emit_ff > pss_pkg::MAX_RESULTS) begin
                  limit_in = pss_pkg::MAX_RESULTS;
               end else begin
                  limit_in = emit_ff;
               end
               now_in      = req_now;
               rd_cnt_in   = '0;
               emit_cnt_in = '0;
               state_in    = pss_pkg::ST_SCAN;
            end
         end
         pss_pkg::ST_SCAN: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            // The newest hit waits in the hold stage until we know whether
            // it is the final beat of the tick.
            if (wb_wr) begin
               emit_cnt_in  = emit_cnt_ff + pss_pkg::EMIT_W'(1);
               hold_vld_in  = 1'b1;
               hold_id_in   = rd_id;
               hold_slot_in = ev_idx_wide[pss_pkg::SLOT_FIELD_W-1:0];
               if (hold_vld_ff) begin
                  out_vld_in  = 1'b1;
                  out_id_in   = hold_id_ff;
                  out_slot_in = hold_slot_ff;
                  out_any_in  = 1'b1;
                  out_last_in = 1'b0;
               end
            end
            if (!ev_vld_ff && !more) begin
               state_in = pss_pkg::ST_FLUSH;
            end
         end
         pss_pkg::ST_FLUSH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_last_in = 1'b1;
               if (hold_vld_ff) begin
                  out_id_in   = hold_id_ff;
                  out_slot_in = hold_slot_ff;
                  out_any_in  = 1'b1;
               end else begin
                  out_id_in   = '0;
                  out_slot_in = '0;
                  out_any_in  = 1'b0;
               end
               hold_vld_in = 1'b0;
               state_in    = pss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pss_pkg::ST_IDLE;
         ev_vld_ff   <= 1'b0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ev_vld_ff   <= ev_vld_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_n_ff    <= scan_n_in;
      limit_ff     <= limit_in;
      now_ff       <= now_in;
      rd_cnt_ff    <= rd_cnt_in;
      emit_cnt_ff  <= emit_cnt_in;
      ev_idx_ff    <= ev_idx_in;
      hold_id_ff   <= hold_id_in;
      hold_slot_ff <= hold_slot_in;
      out_id_ff    <= out_id_in;
      out_slot_ff  <= out_slot_in;
      out_any_ff   <= out_any_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.due_sensor_id = out_id_ff;
   assign rsp_chan.due_slot      = out_slot_ff;
   assign rsp_chan.any_due       = out_any_ff;
   assign rsp_chan.last          = out_last_ff;

endmodule

@@ rtl/core/pss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll scheduler checker
// Port-level assertions on the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [pss_pkg::ACTION_W-1:0]     req_action,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pss_pkg::ID_W-1:0]         rsp_due_sensor_id,
   input logic [pss_pkg::SLOT_FIELD_W-1:0] rsp_due_slot,
   input logic                             rsp_any_due,
   input logic                             rsp_last
);

   // No beat may be offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_due_sensor_id)
         && $stable(rsp_due_slot) && $stable(rsp_any_due) && $stable(rsp_last))
      else $error("stalled response beat changed");

   // A beat without a due sensor, as an empty tick gives, must be zeroed and marked final.
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_any_due |-> rsp_last && (rsp_due_sensor_id == '0)
         && (rsp_due_slot == '0))
      else $error("beat without a due sensor is malformed");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == pss_pkg::ACT_TICK) |=> !req_ready)
      else $error("request taken while a tick scan runs");

   // A load never produces a beat.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == pss_pkg::ACT_LOAD)
         |=> !$rose(rsp_valid))
      else $error("load produced a response beat");

endmodule

bind periodic_sensor_poll_scheduler_unit pss_checker u_pss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_action        (req_chan.action),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_due_sensor_id (rsp_chan.due_sensor_id),
   .rsp_due_slot      (rsp_chan.due_slot),
   .rsp_any_due       (rsp_chan.any_due),
   .rsp_last          (rsp_chan.last)
);
